// File: src/sprite_quad_corner_transform_top_macros.svh
// assertion macros shared by the sprite quad corner transform block
`ifndef SPRITE_QUAD_CORNER_TRANSFORM_TOP_MACROS_SVH
`define SPRITE_QUAD_CORNER_TRANSFORM_TOP_MACROS_SVH

// same-cycle implication
`define SQCT_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SQCT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/sqct_pkg.sv
// shared types, constants and tables of the sprite quad corner transform
`default_nettype none
package sqct_pkg;

  // angle residue within a quadrant and one quarter turn in that scale
  localparam int RES_BITS = 14;
  localparam logic [RES_BITS:0] QUARTER = 15'd16384;

  // divider: one quotient bit per stage, plus the setup stage
  localparam int DIV_STEPS = 17;
  localparam int PIPE_LAT  = DIV_STEPS + 1;
  // sine core stages, padded to match the divider
  localparam int SIN_CORE  = 11;
  localparam int SIN_PAD   = PIPE_LAT - SIN_CORE;

  // queue between front and back
  localparam int QDEPTH = 16;
  localparam int QAW    = 4;

  localparam logic [16:0] TEX_MAX = 17'h1FFFF;
  localparam logic [16:0] SIN_CAP = 17'd65536;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_TEX_W = 2'd0;
  localparam cfg_idx_t REG_TEX_H = 2'd1;

  // issue slot of one sprite; also tags the divider results
  typedef enum logic [1:0] {SLOT_U0, SLOT_U1, SLOT_V0, SLOT_V1} slot_t;

  // per-sprite geometry, written at accept
  typedef struct packed {
    logic signed [24:0] cx;
    logic signed [24:0] cy;
    logic signed [24:0] lx;
    logic signed [24:0] rx;
    logic signed [24:0] ty;
    logic signed [24:0] by;
    logic [31:0]        tint;
    logic [1:0]         quad;
    logic               zero;
  } sprite_ctx_t;

  // per-sprite arithmetic results, written when the pipelines finish
  typedef struct packed {
    logic [16:0] u0;
    logic [16:0] u1;
    logic [16:0] v0;
    logic [16:0] v1;
    logic [16:0] s;
    logic [16:0] c;
  } sprite_res_t;

  // queue status towards front and back
  typedef struct packed {
    logic ctx_full;
    logic res_avail;
  } q_status_t;

  // q30 coefficients of the odd sine polynomial
  function automatic logic [30:0] sin_coef(input logic [2:0] idx);
    logic [30:0] v;
    case (idx)
      3'd0:    v = 31'd1686629713;
      3'd1:    v = 31'd693598668;
      3'd2:    v = 31'd85569306;
      3'd3:    v = 31'd5026995;
      3'd4:    v = 31'd172272;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: src/sqct_div.sv
// pipelined restoring divider for texture coordinates, one quotient bit per stage
`default_nettype none
module sqct_div (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire sqct_pkg::slot_t      in_tag,
  input  wire logic [15:0]          src,
  input  wire logic [15:0]          dvs,
  output logic                      out_valid,
  output sqct_pkg::slot_t           out_tag,
  output logic [16:0]               quo
);

  logic [31:0]     rem_r [0:sqct_pkg::DIV_STEPS];
  logic [16:0]     q_r   [0:sqct_pkg::DIV_STEPS];
  logic [15:0]     d_r   [0:sqct_pkg::DIV_STEPS];
  logic            sat_r [0:sqct_pkg::DIV_STEPS];
  logic            v_r   [0:sqct_pkg::DIV_STEPS];
  sqct_pkg::slot_t tag_r [0:sqct_pkg::DIV_STEPS];

  logic [31:0] num;
  logic        sat0;

  // rounded numerator and saturation test
  assign num  = {src, 16'd0} + {17'd0, dvs[15:1]};
  assign sat0 = (dvs == 16'd0) || ({1'b0, num} >= {dvs, 17'd0});

  // setup stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    tag_r[0] <= in_tag;
    rem_r[0] <= num;
    q_r[0]   <= 17'd0;
    d_r[0]   <= dvs;
    sat_r[0] <= sat0;
  end

  // one quotient bit per stage, msb first
  for (genvar j = 1; j <= sqct_pkg::DIV_STEPS; j++) begin : g_step
    localparam int B = sqct_pkg::DIV_STEPS - j;
    logic [32:0] dsh;
    logic        ge;
    assign dsh = {17'd0, d_r[j-1]} << B;
    assign ge  = {1'b0, rem_r[j-1]} >= dsh;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else begin
        v_r[j] <= v_r[j-1];
      end
      tag_r[j]  <= tag_r[j-1];
      d_r[j]    <= d_r[j-1];
      sat_r[j]  <= sat_r[j-1];
      rem_r[j]  <= ge ? (rem_r[j-1] - dsh[31:0]) : rem_r[j-1];
      q_r[j]    <= q_r[j-1] | (ge ? (17'd1 << B) : 17'd0);
    end
  end

  assign out_valid = v_r[sqct_pkg::DIV_STEPS];
  assign out_tag   = tag_r[sqct_pkg::DIV_STEPS];
  assign quo       = sat_r[sqct_pkg::DIV_STEPS] ? sqct_pkg::TEX_MAX : q_r[sqct_pkg::DIV_STEPS];

endmodule
`default_nettype wire

// File: src/sqct_sin.sv
// pipelined quarter-wave sine polynomial, fixed latency matched to the divider
`default_nettype none
module sqct_sin (
  input  wire logic        clk,
  input  wire logic [14:0] m,
  output logic [16:0]      val
);

  // stage 0 squares, stages 2h+1 / 2h+2 are one horner step
  logic [14:0] m_r  [0:8];
  logic [28:0] mm_r [0:8];
  logic [43:0] ph_r [0:3];
  logic [44:0] pl_r [0:3];
  logic [30:0] p_r  [0:3];
  logic [45:0] fm_r;
  logic [16:0] fr_r;
  logic [16:0] pad_r [0:sqct_pkg::SIN_PAD-1];

  logic [29:0] sq;
  logic [32:0] fsum;
  logic [18:0] frnd;

  assign sq = m * m;

  // square of the residue
  always_ff @(posedge clk) begin
    m_r[0]  <= m;
    mm_r[0] <= sq[28:0];
  end

  for (genvar s = 1; s <= 8; s++) begin : g_carry
    always_ff @(posedge clk) begin
      m_r[s]  <= m_r[s-1];
      mm_r[s] <= mm_r[s-1];
    end
  end

  // horner steps, product split into two partial products
  for (genvar h = 0; h < 4; h++) begin : g_horner
    logic [30:0] p_cur;
    logic [43:0] ph_prod;
    logic [44:0] pl_prod;
    logic [60:0] sum;
    logic [32:0] t;
    logic [30:0] cf;
    if (h == 0) begin : g_first
      assign p_cur = sqct_pkg::sin_coef(3'd4);
    end else begin : g_next
      assign p_cur = p_r[h-1];
    end
    assign ph_prod = p_cur[30:16] * mm_r[2*h];
    assign pl_prod = p_cur[15:0] * mm_r[2*h];
    assign sum = {1'b0, ph_r[h], 16'd0} + {16'd0, pl_r[h]};
    assign t   = sum[60:28];
    assign cf  = sqct_pkg::sin_coef(3'(3 - h));
    always_ff @(posedge clk) begin
      ph_r[h] <= ph_prod;
      pl_r[h] <= pl_prod;
      p_r[h]  <= (t > {2'd0, cf}) ? 31'd0 : (cf - t[30:0]);
    end
  end

  // final multiply by the residue, round to q16 and cap
  assign fsum = {1'b0, fm_r[45:14]} + 33'd8192;
  assign frnd = fsum[32:14];

  always_ff @(posedge clk) begin
    fm_r <= p_r[3] * m_r[8];
    fr_r <= (frnd > {2'd0, sqct_pkg::SIN_CAP}) ? sqct_pkg::SIN_CAP : frnd[16:0];
  end

  // delay to line up with the divider
  always_ff @(posedge clk) begin
    pad_r[0] <= fr_r;
  end
  for (genvar d = 1; d < sqct_pkg::SIN_PAD; d++) begin : g_pad
    always_ff @(posedge clk) begin
      pad_r[d] <= pad_r[d-1];
    end
  end

  assign val = pad_r[sqct_pkg::SIN_PAD-1];

endmodule
`default_nettype wire

// File: src/sqct_front.sv
// front end: accepts sprites, issues divisions and sine terms, gathers results
`default_nettype none
module sqct_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic signed [23:0]     in_pos_x,
  input  wire logic signed [23:0]     in_pos_y,
  input  wire logic [22:0]            in_size_w,
  input  wire logic [22:0]            in_size_h,
  input  wire logic [15:0]            in_angle,
  input  wire logic signed [23:0]     in_pivot_x,
  input  wire logic signed [23:0]     in_pivot_y,
  input  wire logic [15:0]            in_src_left,
  input  wire logic [15:0]            in_src_top,
  input  wire logic [15:0]            in_src_right,
  input  wire logic [15:0]            in_src_bottom,
  input  wire logic [31:0]            in_tint,
  input  wire logic [15:0]            tex_w,
  input  wire logic [15:0]            tex_h,
  input  wire sqct_pkg::q_status_t    q_status,
  output logic                        ctx_push,
  output sqct_pkg::sprite_ctx_t       ctx_data,
  output logic                        res_push,
  output sqct_pkg::sprite_res_t       res_data
);

  logic            busy_r, busy_nxt;
  sqct_pkg::slot_t slot_r, slot_nxt;
  logic [15:0]     srcl_r, srcr_r, srct_r, srcb_r;
  logic [13:0]     resid_r;
  logic            accept;

  logic [15:0]     div_src, div_dvs;
  logic [14:0]     sin_m;
  logic            dv;
  sqct_pkg::slot_t dtag;
  logic [16:0]     quo, sin_val;
  logic [16:0]     u0_r, u1_r, v0_r, s_r, c_r;

  logic signed [24:0] pvx, pvy;

  // a new sprite enters while the last slot of the previous one issues
  assign in_stall = q_status.ctx_full || (busy_r && (slot_r != sqct_pkg::SLOT_V1));
  assign accept   = in_valid && !in_stall;

  // sprite geometry, stored at accept
  assign pvx = 25'(in_pivot_x);
  assign pvy = 25'(in_pivot_y);
  assign ctx_push = accept;
  always_comb begin
    ctx_data.cx   = 25'(in_pos_x) + pvx;
    ctx_data.cy   = 25'(in_pos_y) + pvy;
    ctx_data.lx   = -pvx;
    ctx_data.rx   = $signed({2'b00, in_size_w}) - pvx;
    ctx_data.ty   = -pvy;
    ctx_data.by   = $signed({2'b00, in_size_h}) - pvy;
    ctx_data.tint = in_tint;
    ctx_data.quad = in_angle[15:14];
    ctx_data.zero = (in_angle == 16'd0);
  end

  // issue sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= sqct_pkg::SLOT_U0;
    end else begin
      busy_r <= busy_nxt;
      slot_r <= slot_nxt;
    end
  end

  // issue sequencer next state
  always_comb begin
    busy_nxt = busy_r;
    slot_nxt = slot_r;
    if (accept) begin
      busy_nxt = 1'b1;
      slot_nxt = sqct_pkg::SLOT_U0;
    end else if (busy_r) begin
      unique case (slot_r)
        sqct_pkg::SLOT_U0: slot_nxt = sqct_pkg::SLOT_U1;
        sqct_pkg::SLOT_U1: slot_nxt = sqct_pkg::SLOT_V0;
        sqct_pkg::SLOT_V0: slot_nxt = sqct_pkg::SLOT_V1;
        sqct_pkg::SLOT_V1: busy_nxt = 1'b0;
        default:           busy_nxt = 1'b0;
      endcase
    end
  end

  // operands held for the four issue slots
  always_ff @(posedge clk) begin
    if (accept) begin
      srcl_r  <= in_src_left;
      srcr_r  <= in_src_right;
      srct_r  <= in_src_top;
      srcb_r  <= in_src_bottom;
      resid_r <= in_angle[13:0];
    end
  end

  // operand selection per slot
  always_comb begin
    case (slot_r)
      sqct_pkg::SLOT_U0: div_src = srcl_r;
      sqct_pkg::SLOT_U1: div_src = srcr_r;
      sqct_pkg::SLOT_V0: div_src = srct_r;
      default:           div_src = srcb_r;
    endcase
    div_dvs = ((slot_r == sqct_pkg::SLOT_U0) || (slot_r == sqct_pkg::SLOT_U1)) ? tex_w : tex_h;
    sin_m   = (slot_r == sqct_pkg::SLOT_U0) ? {1'b0, resid_r}
                                            : (sqct_pkg::QUARTER - {1'b0, resid_r});
  end

  sqct_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (busy_r),
    .in_tag    (slot_r),
    .src       (div_src),
    .dvs       (div_dvs),
    .out_valid (dv),
    .out_tag   (dtag),
    .quo       (quo)
  );

  sqct_sin u_sin (
    .clk (clk),
    .m   (sin_m),
    .val (sin_val)
  );

  // gather the four quotients and the sine pair
  always_ff @(posedge clk) begin
    if (dv) begin
      case (dtag)
        sqct_pkg::SLOT_U0: begin
          u0_r <= quo;
          s_r  <= sin_val;
        end
        sqct_pkg::SLOT_U1: begin
          u1_r <= quo;
          c_r  <= sin_val;
        end
        sqct_pkg::SLOT_V0: v0_r <= quo;
        default: ;
      endcase
    end
  end

  assign res_push = dv && (dtag == sqct_pkg::SLOT_V1);
  always_comb begin
    res_data.u0 = u0_r;
    res_data.u1 = u1_r;
    res_data.v0 = v0_r;
    res_data.v1 = quo;
    res_data.s  = s_r;
    res_data.c  = c_r;
  end

endmodule
`default_nettype wire

// File: src/sqct_queue.sv
// sprite queue between front and back: geometry at accept, results at completion
`default_nettype none
module sqct_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   ctx_push,
  input  wire sqct_pkg::sprite_ctx_t  ctx_in,
  input  wire logic                   res_push,
  input  wire sqct_pkg::sprite_res_t  res_in,
  input  wire logic                   pop,
  output sqct_pkg::sprite_ctx_t       ctx_out,
  output sqct_pkg::sprite_res_t       res_out,
  output sqct_pkg::q_status_t         status
);

`include "sprite_quad_corner_transform_top_macros.svh"

  sqct_pkg::sprite_ctx_t ctx_q [0:sqct_pkg::QDEPTH-1];
  sqct_pkg::sprite_res_t res_q [0:sqct_pkg::QDEPTH-1];

  logic [sqct_pkg::QAW-1:0] wpc_r, wpr_r, rp_r;
  logic [sqct_pkg::QAW:0]   ctx_cnt_r, ctx_cnt_nxt, res_cnt_r, res_cnt_nxt;
  logic                     ctx_full;

  assign ctx_full         = (ctx_cnt_r == (sqct_pkg::QAW+1)'(sqct_pkg::QDEPTH));
  assign status.ctx_full  = ctx_full;
  assign status.res_avail = (res_cnt_r != '0);

  // storage writes
  always_ff @(posedge clk) begin
    if (ctx_push) begin
      ctx_q[wpc_r] <= ctx_in;
    end
    if (res_push) begin
      res_q[wpr_r] <= res_in;
    end
  end

  assign ctx_out = ctx_q[rp_r];
  assign res_out = res_q[rp_r];

  // occupancy
  always_comb begin
    ctx_cnt_nxt = ctx_cnt_r + (sqct_pkg::QAW+1)'(ctx_push) - (sqct_pkg::QAW+1)'(pop);
    res_cnt_nxt = res_cnt_r + (sqct_pkg::QAW+1)'(res_push) - (sqct_pkg::QAW+1)'(pop);
  end

  // pointers and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpc_r     <= '0;
      wpr_r     <= '0;
      rp_r      <= '0;
      ctx_cnt_r <= '0;
      res_cnt_r <= '0;
    end else begin
      if (ctx_push) begin
        wpc_r <= wpc_r + 1'b1;
      end
      if (res_push) begin
        wpr_r <= wpr_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      ctx_cnt_r <= ctx_cnt_nxt;
      res_cnt_r <= res_cnt_nxt;
    end
  end

  `SQCT_ASSERT_NOW(a_pop_has_result, clk, rst_n, pop, res_cnt_r != '0, "pop with no finished sprite")
  `SQCT_ASSERT_NOW(a_ctx_room, clk, rst_n, ctx_push, !ctx_full, "sprite accepted into a full queue")
  `SQCT_ASSERT_NOW(a_res_behind_ctx, clk, rst_n, res_push, res_cnt_r < ctx_cnt_r, "result without geometry")
  `SQCT_ASSERT_NEXT(a_res_count, clk, rst_n, res_push && !pop, res_cnt_r == $past(res_cnt_r) + 1'b1, "result count lost a push")

endmodule
`default_nettype wire

// File: src/sqct_back.sv
// back end: walks the four corners, rotates, rounds and saturates
`default_nettype none
module sqct_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire sqct_pkg::q_status_t    q_status,
  input  wire sqct_pkg::sprite_ctx_t  ctx_in,
  input  wire sqct_pkg::sprite_res_t  res_in,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [24:0]          out_vert_x,
  output logic signed [24:0]          out_vert_y,
  output logic [16:0]                 out_tex_u,
  output logic [16:0]                 out_tex_v,
  output logic [31:0]                 out_color,
  output logic [1:0]                  out_corner,
  output logic                        out_last
);

  // current sprite
  logic                  cur_v_r, cur_v_nxt;
  logic [1:0]            k_r;
  sqct_pkg::sprite_ctx_t cur_ctx_r;
  sqct_pkg::sprite_res_t cur_res_r;
  logic signed [17:0]    sn_r, cs_r, sn_map, cs_map, s18, c18;

  // product stage
  logic                  a_v_r;
  logic signed [42:0]    p1_r, p2_r, p3_r, p4_r;
  logic signed [24:0]    acx_r, acy_r;
  logic [16:0]           au_r, av_r;
  logic [31:0]           acol_r;
  logic [1:0]            ak_r;

  // output register
  logic                  out_valid_r;

  logic                  out_take, a_adv, emit, last_k;
  logic signed [24:0]    px, py;
  logic signed [43:0]    dx, dy;
  logic signed [27:0]    rotx, roty;
  logic signed [28:0]    vx, vy;

  function automatic logic signed [24:0] sat25(input logic signed [28:0] v);
    logic signed [24:0] r;
    if (v > 29'sd16777215) begin
      r = 25'sh0FFFFFF;
    end else if (v < -29'sd16777216) begin
      r = 25'sh1000000;
    end else begin
      r = v[24:0];
    end
    return r;
  endfunction

  // flow control
  assign out_take  = !out_valid_r || !out_stall;
  assign a_adv     = !a_v_r || out_take;
  assign emit      = cur_v_r && a_adv;
  assign last_k    = (k_r == 2'd3);
  assign pop       = q_status.res_avail && (!cur_v_r || (emit && last_k));
  assign cur_v_nxt = pop ? 1'b1 : ((emit && last_k) ? 1'b0 : cur_v_r);

  // quadrant folding of the sine pair
  assign s18 = $signed({1'b0, res_in.s});
  assign c18 = $signed({1'b0, res_in.c});
  always_comb begin
    case (ctx_in.quad)
      2'd0: begin sn_map = s18;  cs_map = c18;  end
      2'd1: begin sn_map = c18;  cs_map = -s18; end
      2'd2: begin sn_map = -s18; cs_map = -c18; end
      default: begin sn_map = -c18; cs_map = s18; end
    endcase
    if (ctx_in.zero) begin
      sn_map = 18'sd0;
      cs_map = 18'sd65536;
    end
  end

  // corner sequencing control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r     <= 1'b0;
      k_r         <= 2'd0;
      a_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      if (pop) begin
        k_r <= 2'd0;
      end else if (emit) begin
        k_r <= k_r + 2'd1;
      end
      if (a_adv) begin
        a_v_r <= emit;
      end
      if (out_take) begin
        out_valid_r <= a_v_r;
      end
    end
  end

  // sprite load
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_ctx_r <= ctx_in;
      cur_res_r <= res_in;
      sn_r      <= sn_map;
      cs_r      <= cs_map;
    end
  end

  // corner offsets
  assign px = ((k_r == 2'd0) || (k_r == 2'd3)) ? cur_ctx_r.lx : cur_ctx_r.rx;
  assign py = (k_r[1] == 1'b0) ? cur_ctx_r.ty : cur_ctx_r.by;

  // rotation products
  always_ff @(posedge clk) begin
    if (emit) begin
      p1_r   <= px * cs_r;
      p2_r   <= py * sn_r;
      p3_r   <= px * sn_r;
      p4_r   <= py * cs_r;
      acx_r  <= cur_ctx_r.cx;
      acy_r  <= cur_ctx_r.cy;
      au_r   <= ((k_r == 2'd0) || (k_r == 2'd3)) ? cur_res_r.u0 : cur_res_r.u1;
      av_r   <= (k_r[1] == 1'b0) ? cur_res_r.v0 : cur_res_r.v1;
      acol_r <= cur_ctx_r.tint;
      ak_r   <= k_r;
    end
  end

  // round to nearest, halves upward, then move back to the pivot
  assign dx   = 44'(p1_r) - 44'(p2_r) + 44'sd32768;
  assign dy   = 44'(p3_r) + 44'(p4_r) + 44'sd32768;
  assign rotx = dx[43:16];
  assign roty = dy[43:16];
  assign vx   = 29'(acx_r) + 29'(rotx);
  assign vy   = 29'(acy_r) + 29'(roty);

  // output register
  always_ff @(posedge clk) begin
    if (out_take && a_v_r) begin
      out_vert_x <= sat25(vx);
      out_vert_y <= sat25(vy);
      out_tex_u  <= au_r;
      out_tex_v  <= av_r;
      out_color  <= acol_r;
      out_corner <= ak_r;
      out_last   <= (ak_r == 2'd3);
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: src/sprite_quad_corner_transform_top.sv
// top level of the sprite quad corner transform: config registers and the front/queue/back
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_valid / in_stall | sprite: position, size, angle, pivot, source rect, tint
//  out_    | out | out_valid/out_stall | vertex: position, u, v, colour, corner, last
//  cfg_    | in  | cfg_valid/cfg_ready | register index and 16-bit data (texture size)
//
// a new sprite is accepted as the previous one issues the last of its 4 slots on the shared
// divider (u0, u1, v0, v1); four vertices out at one per cycle while out_stall is low
// from accept to first vertex a sprite passes the issue slots, the 18-stage divider,
// the queue and the 3 back stages (sprite load, products, output register)
// reset clears all control state and sets both texture sizes to 1; no clearing pass
// out_stall holds the back end; in_stall is high while the u0, u1 and v0 slots of an
// accepted sprite issue and while the 16-entry sprite queue is full
`default_nettype none
module sprite_quad_corner_transform_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [23:0]  in_pos_x,
  input  wire logic signed [23:0]  in_pos_y,
  input  wire logic [22:0]         in_size_w,
  input  wire logic [22:0]         in_size_h,
  input  wire logic [15:0]         in_angle,
  input  wire logic signed [23:0]  in_pivot_x,
  input  wire logic signed [23:0]  in_pivot_y,
  input  wire logic [15:0]         in_src_left,
  input  wire logic [15:0]         in_src_top,
  input  wire logic [15:0]         in_src_right,
  input  wire logic [15:0]         in_src_bottom,
  input  wire logic [31:0]         in_tint,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [24:0]       out_vert_x,
  output logic signed [24:0]       out_vert_y,
  output logic [16:0]              out_tex_u,
  output logic [16:0]              out_tex_v,
  output logic [31:0]              out_color,
  output logic [1:0]               out_corner,
  output logic                     out_last,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire sqct_pkg::cfg_idx_t  cfg_index,
  input  wire logic [15:0]         cfg_data
);

  logic [15:0] tex_w_r, tex_h_r;

  sqct_pkg::q_status_t   q_status;
  logic                  ctx_push, res_push, pop;
  sqct_pkg::sprite_ctx_t ctx_data, ctx_head;
  sqct_pkg::sprite_res_t res_data, res_head;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_w_r <= 16'd1;
      tex_h_r <= 16'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sqct_pkg::REG_TEX_W: tex_w_r <= cfg_data;
        sqct_pkg::REG_TEX_H: tex_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sqct_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_size_w     (in_size_w),
    .in_size_h     (in_size_h),
    .in_angle      (in_angle),
    .in_pivot_x    (in_pivot_x),
    .in_pivot_y    (in_pivot_y),
    .in_src_left   (in_src_left),
    .in_src_top    (in_src_top),
    .in_src_right  (in_src_right),
    .in_src_bottom (in_src_bottom),
    .in_tint       (in_tint),
    .tex_w         (tex_w_r),
    .tex_h         (tex_h_r),
    .q_status      (q_status),
    .ctx_push      (ctx_push),
    .ctx_data      (ctx_data),
    .res_push      (res_push),
    .res_data      (res_data)
  );

  sqct_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctx_push (ctx_push),
    .ctx_in   (ctx_data),
    .res_push (res_push),
    .res_in   (res_data),
    .pop      (pop),
    .ctx_out  (ctx_head),
    .res_out  (res_head),
    .status   (q_status)
  );

  sqct_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .ctx_in     (ctx_head),
    .res_in     (res_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_vert_x (out_vert_x),
    .out_vert_y (out_vert_y),
    .out_tex_u  (out_tex_u),
    .out_tex_v  (out_tex_v),
    .out_color  (out_color),
    .out_corner (out_corner),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire

// File: tb/tb_sprite_quad_corner_transform_top.sv
// testbench of the sprite quad corner transform: directed and random sprites checked against a vertex predictor
`default_nettype none
module tb_sprite_quad_corner_transform_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [23:0] pos_x, pos_y;
    logic [22:0] size_w, size_h;
    logic [15:0] angle;
    logic signed [23:0] pivot_x, pivot_y;
    logic [15:0] src_left, src_top, src_right, src_bottom;
    logic [31:0] tint;
  } sprite_t;

  typedef struct {
    logic signed [24:0] vx, vy;
    logic [16:0] u, v;
    logic [31:0] color;
    logic [1:0] corner;
    logic last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] in_pos_x = '0, in_pos_y = '0, in_pivot_x = '0, in_pivot_y = '0;
  logic [22:0] in_size_w = '0, in_size_h = '0;
  logic [15:0] in_angle = '0, in_src_left = '0, in_src_top = '0;
  logic [15:0] in_src_right = '0, in_src_bottom = '0;
  logic [31:0] in_tint = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [24:0] out_vert_x, out_vert_y;
  logic [16:0] out_tex_u, out_tex_v;
  logic [31:0] out_color;
  logic [1:0] out_corner;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  sqct_pkg::cfg_idx_t cfg_index = sqct_pkg::REG_TEX_W;
  logic [15:0] cfg_data = '0;

  sprite_quad_corner_transform_top dut (.*);

  always #6 clk = ~clk;

  // predictor state: texture sizes
  logic [15:0] tex_w = 16'd1, tex_h = 16'd1;

  sprite_t pending_sprites[$];
  vertex_t expected_verts[$];
  int errors = 0;
  int vert_count = 0;
  int sprite_count = 0;
  bit quiet = 1'b0;
  longint cycles = 0;

  // q16 sine of a quarter-turn residue in q30
  function automatic longint quarter_sine(longint unsigned z);
    longint unsigned z2, p, t;
    longint unsigned coef[5] = '{64'd1686629713, 64'd693598668, 64'd85569306,
                                 64'd5026995, 64'd172272};
    z2 = (z * z) >> 30;
    p = coef[4];
    for (int i = 3; i >= 0; i--) begin
      t = (p * z2) >> 30;
      p = (t > coef[i]) ? 0 : coef[i] - t;
    end
    p = (p * z) >> 30;
    p = (p + 8192) >> 14;
    if (p > 65536) p = 65536;
    return longint'(p);
  endfunction

  function automatic longint q16_round(longint v);
    longint t;
    t = v + 32768;
    if (t >= 0) return t >>> 16;
    return -(((-t) + 65535) >>> 16);
  endfunction

  function automatic logic signed [24:0] clamp_pos(longint v);
    if (v > 16777215) return 25'sh0FFFFFF;
    if (v < -16777216) return 25'sh1000000;
    return v[24:0];
  endfunction

  function automatic logic [16:0] tex_coord(logic [15:0] src, logic [15:0] dv);
    longint unsigned q;
    if (dv == 0) return sqct_pkg::TEX_MAX;
    q = ((longint'(src) << 16) + (dv >> 1)) / dv;
    return (q > 131071) ? sqct_pkg::TEX_MAX : q[16:0];
  endfunction

  // four corners of one sprite
  task automatic predict_quad(sprite_t s);
    longint cx, cy, lx, rx, ty, by, sn, cs, px, py, vx, vy, sv, cv;
    longint unsigned z;
    vertex_t vt;
    cx = longint'(s.pos_x) + longint'(s.pivot_x);
    cy = longint'(s.pos_y) + longint'(s.pivot_y);
    lx = -longint'(s.pivot_x);
    rx = longint'(s.size_w) - longint'(s.pivot_x);
    ty = -longint'(s.pivot_y);
    by = longint'(s.size_h) - longint'(s.pivot_y);
    sn = 0;
    cs = 65536;
    if (s.angle != 0) begin
      z = longint'(s.angle[13:0]) << 16;
      sv = quarter_sine(z);
      cv = quarter_sine(64'd1073741824 - z);
      case (s.angle[15:14])
        2'd0: begin sn = sv; cs = cv; end
        2'd1: begin sn = cv; cs = -sv; end
        2'd2: begin sn = -sv; cs = -cv; end
        default: begin sn = -cv; cs = sv; end
      endcase
    end
    for (int k = 0; k < 4; k++) begin
      px = (k == 0 || k == 3) ? lx : rx;
      py = (k < 2) ? ty : by;
      if (s.angle == 0) begin
        vx = cx + px;
        vy = cy + py;
      end else begin
        vx = cx + q16_round(px * cs - py * sn);
        vy = cy + q16_round(px * sn + py * cs);
      end
      vt.vx = clamp_pos(vx);
      vt.vy = clamp_pos(vy);
      vt.u = tex_coord((k == 0 || k == 3) ? s.src_left : s.src_right, tex_w);
      vt.v = tex_coord((k < 2) ? s.src_top : s.src_bottom, tex_h);
      vt.color = s.tint;
      vt.corner = k[1:0];
      vt.last = (k == 3);
      expected_verts.insert(expected_verts.size(), vt);
    end
  endtask

  function automatic sprite_t random_sprite();
    sprite_t s;
    int mode;
    mode = $urandom_range(0, 3);
    s.pos_x = 24'($urandom);
    s.pos_y = 24'($urandom);
    s.size_w = 23'($urandom);
    s.size_h = 23'($urandom);
    s.pivot_x = 24'($urandom);
    s.pivot_y = 24'($urandom);
    // mostly on-screen sized sprites, some full range
    if (mode != 0) begin
      s.pos_x = $signed(24'($urandom_range(0, 524288))) - 24'sd262144;
      s.pos_y = $signed(24'($urandom_range(0, 524288))) - 24'sd262144;
      s.size_w = 23'($urandom_range(0, 65535));
      s.size_h = 23'($urandom_range(0, 65535));
      s.pivot_x = $signed(24'($urandom_range(0, 65535))) - 24'sd16384;
      s.pivot_y = $signed(24'($urandom_range(0, 65535))) - 24'sd16384;
    end
    s.angle = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
    if ($urandom_range(0, 7) == 0) s.angle = 16'($urandom_range(0, 3)) << 14;
    s.src_left = 16'($urandom);
    s.src_top = 16'($urandom);
    s.src_right = 16'($urandom);
    s.src_bottom = 16'($urandom);
    if (mode == 3) begin
      s.src_left = 16'($urandom_range(0, tex_w));
      s.src_right = 16'($urandom_range(0, tex_w));
      s.src_top = 16'($urandom_range(0, tex_h));
      s.src_bottom = 16'($urandom_range(0, tex_h));
    end
    s.tint = $urandom;
    return s;
  endfunction

  // request driver with random idle bursts
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_quad(pending_sprites.pop_front());
        sprite_count++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (pending_sprites.size() > 0) begin
          in_valid <= 1'b1;
          in_pos_x <= pending_sprites[0].pos_x;
          in_pos_y <= pending_sprites[0].pos_y;
          in_size_w <= pending_sprites[0].size_w;
          in_size_h <= pending_sprites[0].size_h;
          in_angle <= pending_sprites[0].angle;
          in_pivot_x <= pending_sprites[0].pivot_x;
          in_pivot_y <= pending_sprites[0].pivot_y;
          in_src_left <= pending_sprites[0].src_left;
          in_src_top <= pending_sprites[0].src_top;
          in_src_right <= pending_sprites[0].src_right;
          in_src_bottom <= pending_sprites[0].src_bottom;
          in_tint <= pending_sprites[0].tint;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // vertex monitor with random stall bursts
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        vert_count++;
        if (expected_verts.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected vertex corner %0d", out_corner);
        end else begin
          vertex_t e;
          e = expected_verts.pop_front();
          if (out_vert_x !== e.vx || out_vert_y !== e.vy || out_tex_u !== e.u ||
              out_tex_v !== e.v || out_color !== e.color || out_corner !== e.corner ||
              out_last !== e.last) begin
            errors++;
            if (errors <= 10) begin
              $display("vertex mismatch: exp x=%0d y=%0d u=%0d v=%0d c=%h k=%0d l=%0b",
                       e.vx, e.vy, e.u, e.v, e.color, e.corner, e.last);
              $display("                 got x=%0d y=%0d u=%0d v=%0d c=%h k=%0d l=%0b",
                       out_vert_x, out_vert_y, out_tex_u, out_tex_v, out_color,
                       out_corner, out_last);
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(sqct_pkg::cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == sqct_pkg::REG_TEX_W) tex_w = val;
    else tex_h = val;
  endtask

  task automatic drain();
    while (pending_sprites.size() > 0 || in_valid || expected_verts.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic add_edge(logic signed [23:0] p, logic [22:0] sz, logic [15:0] a,
                          logic signed [23:0] pv, logic [15:0] src);
    sprite_t s;
    s.pos_x = p; s.pos_y = -p;
    s.size_w = sz; s.size_h = sz;
    s.angle = a;
    s.pivot_x = pv; s.pivot_y = -pv;
    s.src_left = src; s.src_top = ~src; s.src_right = ~src; s.src_bottom = src;
    s.tint = {src, ~src};
    pending_sprites.insert(pending_sprites.size(), s);
  endtask

  initial begin
    logic [15:0] tex_sizes[6] = '{16'd1, 16'd65535, 16'd0, 16'd256, 16'd3, 16'd1000};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed sprites at reset texture sizes: extremes, quadrant angles, overflow
    add_edge(24'sd0, 23'd0, 16'd0, 24'sd0, 16'd0);
    add_edge(24'sh7FFFFF, 23'h7FFFFF, 16'd0, 24'sh7FFFFF, 16'hFFFF);
    add_edge(-24'sh800000, 23'h7FFFFF, 16'd0, -24'sh800000, 16'd1);
    add_edge(24'sd2560, 23'd4096, 16'h4000, 24'sd2048, 16'd7);
    add_edge(24'sd2560, 23'd4096, 16'h8000, 24'sd2048, 16'd7);
    add_edge(24'sd2560, 23'd4096, 16'hC000, 24'sd2048, 16'd7);
    add_edge(24'sd100, 23'd333, 16'd1, 24'sd0, 16'd2);
    add_edge(24'sd100, 23'd333, 16'hFFFF, 24'sd17, 16'd2);
    add_edge(24'sh7FFFFF, 23'h7FFFFF, 16'h2000, -24'sh800000, 16'h8000);
    add_edge(-24'sh800000, 23'h7FFFFF, 16'h6000, 24'sh7FFFFF, 16'h5555);
    add_edge(24'sh555555, 23'h2AAAAA, 16'hAAAA, 24'shAAAAAA, 16'hAAAA);
    drain();
    // random phases across texture sizes, zero divisor included
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(sqct_pkg::REG_TEX_W, tex_sizes[ph]);
      write_reg(sqct_pkg::REG_TEX_H, tex_sizes[5 - ph]);
      if (ph == 5) quiet = 1'b1;
      for (int i = 0; i < 75; i++) pending_sprites.insert(pending_sprites.size(), random_sprite());
      drain();
    end
    $display("covered %0d sprites, %0d vertices over 7 texture size settings",
             sprite_count, vert_count);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
+incdir+src
src/sqct_pkg.sv
src/sqct_div.sv
src/sqct_sin.sv
src/sqct_front.sv
src/sqct_queue.sv
src/sqct_back.sv
src/sprite_quad_corner_transform_top.sv
tb/tb_sprite_quad_corner_transform_top.sv
